// ----- hw/rtl/i2c_eeprom_paged_access_sequencer_core_macros.svh -----
// assertion helpers for the sequencer core
`ifndef I2C_EEPROM_PAGED_ACCESS_SEQUENCER_CORE_MACROS_SVH
`define I2C_EEPROM_PAGED_ACCESS_SEQUENCER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define EPAS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// antecedent implies consequent in the next cycle
`define EPAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

// ----- hw/rtl/epas_pkg.sv -----
package epas_pkg;

    localparam logic [1:0] MODE_REQ  = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_BUS  = 2'd2;

    localparam logic [3:0] CMD_START     = 4'd0;
    localparam logic [3:0] CMD_STOP      = 4'd1;
    localparam logic [3:0] CMD_WRITE     = 4'd2;
    localparam logic [3:0] CMD_READ_ACK  = 4'd3;
    localparam logic [3:0] CMD_READ_NACK = 4'd4;
    localparam logic [3:0] CMD_DELAY     = 4'd5;
    localparam logic [3:0] CMD_DATA_REQ  = 4'd6;
    localparam logic [3:0] CMD_READ_DATA = 4'd7;
    localparam logic [3:0] CMD_DONE      = 4'd8;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NACK    = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT = 2'd2;

    localparam logic [2:0] CFG_DEVICE_ADDRESS = 3'd0;
    localparam logic [2:0] CFG_TWO_BYTE_ADDR  = 3'd1;
    localparam logic [2:0] CFG_PAGE_LOG2      = 3'd2;
    localparam logic [2:0] CFG_POLL_LIMIT     = 3'd3;
    localparam logic [2:0] CFG_WRITE_DELAY    = 3'd4;

    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic [1:0]  mode;
        logic        is_write;
        logic [15:0] start_address;
        logic [15:0] byte_count;
        logic [15:0] buffer_offset;
        logic [7:0]  write_byte;
        logic        bus_nack;
        logic [7:0]  bus_read_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  command;
        logic [7:0]  bus_byte;
        logic [15:0] buffer_index;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    function automatic t_out_item mk_result(logic [3:0] cmd, logic [7:0] b,
                                            logic [15:0] idx, logic [1:0] st);
        t_out_item r;
        r.command      = cmd;
        r.bus_byte     = b;
        r.buffer_index = idx;
        r.status       = st;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

// ----- hw/rtl/epas_in_if.sv -----
interface epas_in_if;
    logic                valid;
    logic                ready;
    epas_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/epas_out_if.sv -----
interface epas_out_if;
    logic                valid;
    logic                ready;
    epas_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/i2c_eeprom_paged_access_sequencer_core.sv -----
// Paged 24Cxx-style EEPROM access sequencer. Each accepted input transaction (a new request, a
// write data byte or a bus response) is handled in the cycle it is accepted and yields zero to
// four result transactions, which are held in a four-entry output queue and handed out one per
// cycle while the output is ready. A new input is taken whenever the queue is empty, or holds
// one result that is being taken in the same cycle, so a new input waits until all but the
// last result of the one before have been handed out. Configuration writes take effect
// at once and should only be made while no request is in progress.
`include "i2c_eeprom_paged_access_sequencer_core_macros.svh"

module i2c_eeprom_paged_access_sequencer_core #(
    parameter int ADDRESS_BITS   = 16,
    parameter int MAX_PAGE_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    epas_in_if.sink     i_in,
    epas_out_if.source  o_out
);
    import epas_pkg::*;

    localparam int CHUNK_W  = $clog2(MAX_PAGE_BYTES + 1);
    localparam int LOG_MAX  = $clog2(MAX_PAGE_BYTES);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_POLL     = 4'd1;
    localparam logic [3:0] PH_ADDR_HI  = 4'd2;
    localparam logic [3:0] PH_ADDR_LO  = 4'd3;
    localparam logic [3:0] PH_DATA_REQ = 4'd4;
    localparam logic [3:0] PH_DATA     = 4'd5;
    localparam logic [3:0] PH_RDEV     = 4'd6;
    localparam logic [3:0] PH_RESTART  = 4'd7;
    localparam logic [3:0] PH_READ     = 4'd8;
    localparam logic [3:0] PH_DELAY    = 4'd9;

    logic [7:0]  r_dev;
    logic        r_two;
    logic [3:0]  r_psl;
    logic [15:0] r_poll_lim;
    logic [15:0] r_wdelay;

    logic [3:0]              r_phase, n_phase;
    logic                    r_dir, n_dir;
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    logic [16:0]             r_bytes, n_bytes;
    logic [CHUNK_W-1:0]      r_chunk, n_chunk;
    logic [15:0]             r_buf, n_buf;
    logic [15:0]             r_pc, n_pc;

    t_out_item r_q [MAX_RESULTS];
    logic [2:0] r_cnt;

    t_out_item  w_res [MAX_RESULTS];
    logic [2:0] w_n;
    logic       w_acc;
    logic       w_pop;

    assign w_pop       = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && o_out.ready);
    assign w_acc       = i_in.valid && i_in.ready;
    assign o_out.valid = (r_cnt != 3'd0);
    assign o_out.payload = r_q[0];

    always_comb begin
        logic               do_end;
        logic               do_begin;
        logic [1:0]         end_st;
        logic [3:0]         l;
        logic [CHUNK_W-1:0] pg;
        logic [CHUNK_W-1:0] off;
        logic [CHUNK_W-1:0] room;
        logic [CHUNK_W-1:0] chunk;
        logic [15:0]        a16;
        n_phase  = r_phase;
        n_dir    = r_dir;
        n_addr   = r_addr;
        n_bytes  = r_bytes;
        n_chunk  = r_chunk;
        n_buf    = r_buf;
        n_pc     = r_pc;
        w_n      = 3'd0;
        do_end   = 1'b0;
        do_begin = 1'b0;
        end_st   = STAT_OK;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            w_res[i] = mk_result(CMD_START, 8'd0, 16'd0, STAT_OK);
        end
        if (w_acc) begin
            case (i_in.payload.mode)
                MODE_REQ: begin
                    if (r_phase == PH_IDLE) begin
                        n_dir    = i_in.payload.is_write;
                        n_addr   = i_in.payload.start_address[ADDRESS_BITS-1:0];
                        n_bytes  = {1'b0, i_in.payload.byte_count};
                        n_buf    = i_in.payload.buffer_offset;
                        n_chunk  = '0;
                        n_pc     = 16'd0;
                        do_begin = 1'b1;
                    end
                end
                MODE_DATA: begin
                    if (r_phase == PH_DATA_REQ) begin
                        w_res[w_n[1:0]] = mk_result(CMD_WRITE, i_in.payload.write_byte,
                                                    16'd0, STAT_OK);
                        w_n = w_n + 3'd1;
                        n_phase = PH_DATA;
                    end
                end
                MODE_BUS: begin
                    a16 = 16'(r_addr);
                    case (r_phase)
                        PH_POLL: begin
                            if (!i_in.payload.bus_nack) begin
                                w_res[w_n[1:0]] = mk_result(CMD_WRITE,
                                    r_two ? a16[15:8] : a16[7:0], 16'd0, STAT_OK);
                                w_n = w_n + 3'd1;
                                n_phase = r_two ? PH_ADDR_HI : PH_ADDR_LO;
                            end else begin
                                n_pc = r_pc + 16'd1;
                                if (n_pc >= r_poll_lim || n_pc == 16'd0) begin
                                    do_end = 1'b1;
                                    end_st = STAT_TIMEOUT;
                                end else begin
                                    w_res[w_n[1:0]] = mk_result(CMD_START, 8'd0, 16'd0,
                                                                STAT_OK);
                                    w_n = w_n + 3'd1;
                                    w_res[w_n[1:0]] = mk_result(CMD_WRITE,
                                        {r_dev[7:1], 1'b0}, 16'd0, STAT_OK);
                                    w_n = w_n + 3'd1;
                                end
                            end
                        end
                        PH_RDEV: begin
                            if (i_in.payload.bus_nack) begin
                                do_end = 1'b1;
                                end_st = STAT_NACK;
                            end else begin
                                w_res[w_n[1:0]] = mk_result(CMD_WRITE,
                                    r_two ? a16[15:8] : a16[7:0], 16'd0, STAT_OK);
                                w_n = w_n + 3'd1;
                                n_phase = r_two ? PH_ADDR_HI : PH_ADDR_LO;
                            end
                        end
                        PH_ADDR_HI: begin
                            if (i_in.payload.bus_nack) begin
                                do_end = 1'b1;
                                end_st = STAT_NACK;
                            end else begin
                                w_res[w_n[1:0]] = mk_result(CMD_WRITE, a16[7:0], 16'd0,
                                                            STAT_OK);
                                w_n = w_n + 3'd1;
                                n_phase = PH_ADDR_LO;
                            end
                        end
                        PH_ADDR_LO: begin
                            if (i_in.payload.bus_nack) begin
                                do_end = 1'b1;
                                end_st = STAT_NACK;
                            end else if (r_dir) begin
                                w_res[w_n[1:0]] = mk_result(CMD_DATA_REQ, 8'd0, r_buf,
                                                            STAT_OK);
                                w_n = w_n + 3'd1;
                                n_phase = PH_DATA_REQ;
                            end else begin
                                w_res[w_n[1:0]] = mk_result(CMD_START, 8'd0, 16'd0, STAT_OK);
                                w_n = w_n + 3'd1;
                                w_res[w_n[1:0]] = mk_result(CMD_WRITE, r_dev | 8'd1, 16'd0,
                                                            STAT_OK);
                                w_n = w_n + 3'd1;
                                n_phase = PH_RESTART;
                            end
                        end
                        PH_RESTART: begin
                            if (i_in.payload.bus_nack) begin
                                do_end = 1'b1;
                                end_st = STAT_NACK;
                            end else begin
                                w_res[w_n[1:0]] = mk_result(
                                    (r_chunk == CHUNK_W'(1)) ? CMD_READ_NACK : CMD_READ_ACK,
                                    8'd0, 16'd0, STAT_OK);
                                w_n = w_n + 3'd1;
                                n_phase = PH_READ;
                            end
                        end
                        PH_DATA: begin
                            if (i_in.payload.bus_nack) begin
                                do_end = 1'b1;
                                end_st = STAT_NACK;
                            end else begin
                                n_addr  = r_addr + ADDRESS_BITS'(1);
                                n_buf   = r_buf + 16'd1;
                                n_chunk = r_chunk - CHUNK_W'(1);
                                if (n_chunk != '0) begin
                                    w_res[w_n[1:0]] = mk_result(CMD_DATA_REQ, 8'd0, n_buf,
                                                                STAT_OK);
                                    w_n = w_n + 3'd1;
                                    n_phase = PH_DATA_REQ;
                                end else begin
                                    do_end = 1'b1;
                                end
                            end
                        end
                        PH_READ: begin
                            w_res[w_n[1:0]] = mk_result(CMD_READ_DATA,
                                i_in.payload.bus_read_byte, r_buf, STAT_OK);
                            w_n = w_n + 3'd1;
                            n_addr  = r_addr + ADDRESS_BITS'(1);
                            n_buf   = r_buf + 16'd1;
                            n_chunk = r_chunk - CHUNK_W'(1);
                            if (n_chunk != '0) begin
                                w_res[w_n[1:0]] = mk_result(
                                    (n_chunk == CHUNK_W'(1)) ? CMD_READ_NACK : CMD_READ_ACK,
                                    8'd0, 16'd0, STAT_OK);
                                w_n = w_n + 3'd1;
                            end else begin
                                do_end = 1'b1;
                            end
                        end
                        PH_DELAY: do_begin = 1'b1;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        // chunk end
        if (do_end) begin
            w_res[w_n[1:0]] = mk_result(CMD_STOP, 8'd0, 16'd0, end_st);
            w_n = w_n + 3'd1;
            n_addr  = n_addr + ADDRESS_BITS'(n_chunk);
            n_buf   = n_buf + 16'(n_chunk);
            n_chunk = '0;
            if (n_dir) begin
                w_res[w_n[1:0]] = mk_result(CMD_DELAY, r_wdelay[7:0], r_wdelay, STAT_OK);
                w_n = w_n + 3'd1;
                n_phase = PH_DELAY;
            end else begin
                do_begin = 1'b1;
            end
        end

        // next chunk
        l = r_psl;
        if (l < 4'd3) l = 4'd3;
        if (l > 4'(LOG_MAX)) l = 4'(LOG_MAX);
        pg    = CHUNK_W'(1) << l;
        a16   = 16'(n_addr);
        off   = a16[CHUNK_W-1:0] & (pg - CHUNK_W'(1));
        room  = pg - off;
        chunk = (n_bytes < 17'(room)) ? n_bytes[CHUNK_W-1:0] : room;
        if (do_begin) begin
            if (n_bytes == 17'd0) begin
                w_res[w_n[1:0]] = mk_result(CMD_DONE, 8'd0, 16'd0, STAT_OK);
                w_n = w_n + 3'd1;
                n_phase = PH_IDLE;
            end else begin
                n_bytes = n_bytes - 17'(chunk);
                n_chunk = chunk;
                if (n_dir) begin
                    w_res[w_n[1:0]] = mk_result(CMD_STOP, 8'd0, 16'd0, STAT_OK);
                    w_n = w_n + 3'd1;
                    n_pc = 16'd0;
                    n_phase = PH_POLL;
                end else begin
                    n_phase = PH_RDEV;
                end
                w_res[w_n[1:0]] = mk_result(CMD_START, 8'd0, 16'd0, STAT_OK);
                w_n = w_n + 3'd1;
                w_res[w_n[1:0]] = mk_result(CMD_WRITE, {r_dev[7:1], 1'b0}, 16'd0, STAT_OK);
                w_n = w_n + 3'd1;
            end
        end

        for (int i = 0; i < MAX_RESULTS; i++) begin
            w_res[i].last = (w_n == 3'(i + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev      <= 8'd160;
            r_two      <= 1'b0;
            r_psl      <= 4'd3;
            r_poll_lim <= 16'd1000;
            r_wdelay   <= 16'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEVICE_ADDRESS: r_dev      <= i_cfg_data[7:0];
                CFG_TWO_BYTE_ADDR:  r_two      <= i_cfg_data[0];
                CFG_PAGE_LOG2:      r_psl      <= i_cfg_data[3:0];
                CFG_POLL_LIMIT:     r_poll_lim <= i_cfg_data;
                CFG_WRITE_DELAY:    r_wdelay   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_dir   <= 1'b0;
            r_addr  <= '0;
            r_bytes <= 17'd0;
            r_chunk <= '0;
            r_buf   <= 16'd0;
            r_pc    <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_dir   <= n_dir;
            r_addr  <= n_addr;
            r_bytes <= n_bytes;
            r_chunk <= n_chunk;
            r_buf   <= n_buf;
            r_pc    <= n_pc;
        end
    end

    // result queue, head at entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (w_acc) begin
            r_cnt <= w_n;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                r_q[i] <= w_res[i];
            end
        end else if (w_pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                r_q[i] <= r_q[i + 1];
            end
        end
    end

    `EPAS_ASSERT_IMPL(a_no_accept_when_full, r_cnt > 3'd1, !i_in.ready)
    `EPAS_ASSERT_NEXT(a_queue_load, w_acc, r_cnt == $past(w_n))
    `EPAS_ASSERT_IMPL(a_idle_no_chunk, r_phase == PH_IDLE, r_chunk == '0)

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import epas_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_POLL, SEQ_ADDR_HI, SEQ_ADDR_LO, SEQ_DATA_REQ, SEQ_DATA,
        SEQ_RDEV, SEQ_RESTART, SEQ_READ, SEQ_DELAY
    } seq_phase_e;

    typedef struct {
        t_in_item  item;
        int        typed_n;
        t_out_item typed_res;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    epas_in_if  in_ch ();
    epas_out_if out_ch ();

    i2c_eeprom_paged_access_sequencer_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // shadow registers and sequencer state
    logic [7:0]  dev_addr;
    logic        two_byte;
    logic [3:0]  page_log2;
    logic [15:0] poll_lim;
    logic [15:0] wr_delay;
    seq_phase_e  ph;
    logic        dir_wr;
    logic [15:0] cur_addr;
    logic [16:0] bytes_left;
    logic [8:0]  chunk_left;
    logic [15:0] buf_pos;
    logic [15:0] poll_cnt;

    t_out_item step_res[$];
    t_out_item pending_res[$];
    int        errors = 0;
    bit        calm = 1'b0;
    bit        bulk_req = 1'b0;
    bit        bulk_on = 1'b0;

    task automatic emit(logic [3:0] cmd, logic [7:0] b, logic [15:0] idx, logic [1:0] st);
        t_out_item r;
        r.command      = cmd;
        r.bus_byte     = b;
        r.buffer_index = idx;
        r.status       = st;
        r.last         = 1'b0;
        if (step_res.size() < MAX_RESULTS) step_res.push_back(r);
    endtask

    function automatic logic [8:0] page_len();
        logic [3:0] l;
        l = page_log2;
        if (l < 4'd3) l = 4'd3;
        if (l > 4'd8) l = 4'd8;
        return 9'd1 << l;
    endfunction

    task automatic issue_read();
        emit(chunk_left == 9'd1 ? CMD_READ_NACK : CMD_READ_ACK, 8'd0, 16'd0, STAT_OK);
        ph = SEQ_READ;
    endtask

    task automatic next_chunk();
        logic [16:0] pg, room, chunk;
        if (bytes_left == 17'd0) begin
            emit(CMD_DONE, 8'd0, 16'd0, STAT_OK);
            ph = SEQ_IDLE;
            return;
        end
        pg = 17'(page_len());
        room = pg - (17'(cur_addr) % pg);
        chunk = bytes_left < room ? bytes_left : room;
        bytes_left -= chunk;
        chunk_left = 9'(chunk);
        if (dir_wr) begin
            emit(CMD_STOP, 8'd0, 16'd0, STAT_OK);
            poll_cnt = '0;
            ph = SEQ_POLL;
        end else begin
            ph = SEQ_RDEV;
        end
        emit(CMD_START, 8'd0, 16'd0, STAT_OK);
        emit(CMD_WRITE, dev_addr & 8'hFE, 16'd0, STAT_OK);
    endtask

    task automatic close_chunk(logic [1:0] st);
        emit(CMD_STOP, 8'd0, 16'd0, st);
        cur_addr = cur_addr + 16'(chunk_left);
        buf_pos = buf_pos + 16'(chunk_left);
        chunk_left = '0;
        if (dir_wr) begin
            emit(CMD_DELAY, wr_delay[7:0], wr_delay, STAT_OK);
            ph = SEQ_DELAY;
        end else begin
            next_chunk();
        end
    endtask

    task automatic step_on();
        cur_addr = cur_addr + 16'd1;
        buf_pos = buf_pos + 16'd1;
        chunk_left = chunk_left - 9'd1;
    endtask

    task automatic send_mem_addr();
        if (two_byte) begin
            emit(CMD_WRITE, cur_addr[15:8], 16'd0, STAT_OK);
            ph = SEQ_ADDR_HI;
        end else begin
            emit(CMD_WRITE, cur_addr[7:0], 16'd0, STAT_OK);
            ph = SEQ_ADDR_LO;
        end
    endtask

    task automatic predict(t_in_item it);
        step_res.delete();
        case (it.mode)
            MODE_REQ: begin
                if (ph == SEQ_IDLE) begin
                    dir_wr = it.is_write;
                    cur_addr = it.start_address;
                    bytes_left = 17'(it.byte_count);
                    buf_pos = it.buffer_offset;
                    chunk_left = '0;
                    poll_cnt = '0;
                    next_chunk();
                end
            end
            MODE_DATA: begin
                if (ph == SEQ_DATA_REQ) begin
                    emit(CMD_WRITE, it.write_byte, 16'd0, STAT_OK);
                    ph = SEQ_DATA;
                end
            end
            MODE_BUS: begin
                case (ph)
                    SEQ_POLL: begin
                        if (!it.bus_nack) begin
                            send_mem_addr();
                        end else begin
                            poll_cnt = poll_cnt + 16'd1;
                            if (poll_cnt >= poll_lim || poll_cnt == 16'd0) begin
                                close_chunk(STAT_TIMEOUT);
                            end else begin
                                emit(CMD_START, 8'd0, 16'd0, STAT_OK);
                                emit(CMD_WRITE, dev_addr & 8'hFE, 16'd0, STAT_OK);
                            end
                        end
                    end
                    SEQ_RDEV: begin
                        if (it.bus_nack) close_chunk(STAT_NACK);
                        else send_mem_addr();
                    end
                    SEQ_ADDR_HI: begin
                        if (it.bus_nack) begin
                            close_chunk(STAT_NACK);
                        end else begin
                            emit(CMD_WRITE, cur_addr[7:0], 16'd0, STAT_OK);
                            ph = SEQ_ADDR_LO;
                        end
                    end
                    SEQ_ADDR_LO: begin
                        if (it.bus_nack) begin
                            close_chunk(STAT_NACK);
                        end else if (dir_wr) begin
                            emit(CMD_DATA_REQ, 8'd0, buf_pos, STAT_OK);
                            ph = SEQ_DATA_REQ;
                        end else begin
                            emit(CMD_START, 8'd0, 16'd0, STAT_OK);
                            emit(CMD_WRITE, dev_addr | 8'h01, 16'd0, STAT_OK);
                            ph = SEQ_RESTART;
                        end
                    end
                    SEQ_RESTART: begin
                        if (it.bus_nack) close_chunk(STAT_NACK);
                        else issue_read();
                    end
                    SEQ_DATA: begin
                        if (it.bus_nack) begin
                            close_chunk(STAT_NACK);
                        end else begin
                            step_on();
                            if (chunk_left != 9'd0) begin
                                emit(CMD_DATA_REQ, 8'd0, buf_pos, STAT_OK);
                                ph = SEQ_DATA_REQ;
                            end else begin
                                close_chunk(STAT_OK);
                            end
                        end
                    end
                    SEQ_READ: begin
                        emit(CMD_READ_DATA, it.bus_read_byte, buf_pos, STAT_OK);
                        step_on();
                        if (chunk_left != 9'd0) issue_read();
                        else close_chunk(STAT_OK);
                    end
                    SEQ_DELAY: next_chunk();
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    endtask

    function automatic t_in_item mk_in(logic [1:0] m, logic w, logic [15:0] sa,
                                       logic [15:0] bc, logic [15:0] bo, logic [7:0] wb,
                                       logic nk, logic [7:0] rb);
        t_in_item it;
        it.mode = m;
        it.is_write = w;
        it.start_address = sa;
        it.byte_count = bc;
        it.buffer_offset = bo;
        it.write_byte = wb;
        it.bus_nack = nk;
        it.bus_read_byte = rb;
        return it;
    endfunction

    function automatic t_out_item mk_out(logic [3:0] cmd);
        t_out_item r;
        r = '0;
        r.command = cmd;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it = mk_in(MODE_BUS, 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom), 1'($urandom), 8'($urandom));
        if ($urandom_range(0, 9) == 0 && !bulk_on) begin
            it.mode = ph == SEQ_IDLE ? 2'($urandom_range(1, 3)) : 2'($urandom_range(0, 3));
            return it;
        end
        case (ph)
            SEQ_IDLE: begin
                it.mode = MODE_REQ;
                if (bulk_req) begin
                    it.is_write = 1'b0;
                    it.byte_count = 16'h0801;
                    bulk_req = 1'b0;
                    bulk_on = 1'b1;
                end else if ($urandom_range(0, 7) == 0) begin
                    it.byte_count = 16'($urandom_range(13, 40));
                end else begin
                    it.byte_count = 16'($urandom_range(0, 12));
                end
            end
            SEQ_DATA_REQ: it.mode = MODE_DATA;
            SEQ_POLL: it.bus_nack = 1'($urandom_range(0, 1));
            SEQ_READ, SEQ_DELAY: ;
            default: it.bus_nack = bulk_on || $urandom_range(0, 11) == 0;
        endcase
        return it;
    endfunction

    task automatic drive(t_in_item it, output int n_res);
        bit acc;
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        do begin
            @(negedge i_clk);
            acc = in_ch.ready;
            @(posedge i_clk);
        end while (!acc);
        predict(it);
        n_res = step_res.size();
        foreach (step_res[k]) pending_res.push_back(step_res[k]);
    endtask

    // rows whose outcome is typed in: state already advanced by the caller
    task automatic drive_typed(t_in_item it);
        bit acc;
        int gap;
        gap = $urandom_range(0, 14);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        do begin
            @(negedge i_clk);
            acc = in_ch.ready;
            @(posedge i_clk);
        end while (!acc);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DEVICE_ADDRESS: dev_addr = val[7:0];
            CFG_TWO_BYTE_ADDR:  two_byte = val[0];
            CFG_PAGE_LOG2:      page_log2 = val[3:0];
            CFG_POLL_LIMIT:     poll_lim = val;
            CFG_WRITE_DELAY:    wr_delay = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
    endtask

    task automatic run_random(int target);
        int done_n, n;
        t_in_item it;
        done_n = 0;
        while (done_n < target || ph != SEQ_IDLE) begin
            if ($urandom_range(0, 19) == 0) calm = ~calm;
            it = rand_item();
            drive(it, n);
            if (n > 0) done_n++;
            if (ph == SEQ_IDLE) bulk_on = 1'b0;
        end
        calm = 1'b0;
    endtask

    // result checking
    initial begin
        t_out_item got, want;
        bit v;
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do begin
                @(negedge i_clk);
                v = out_ch.valid && out_ch.ready;
                got = out_ch.payload;
                @(posedge i_clk);
            end while (!v);
            if (pending_res.size() == 0) begin
                $error("unexpected transaction: command %0d", got.command);
                errors++;
            end else begin
                want = pending_res.pop_front();
                if (got.command !== want.command) begin
                    $error("command: expected %0d, actual %0d", want.command, got.command);
                    errors++;
                end
                if (got.bus_byte !== want.bus_byte) begin
                    $error("bus_byte: expected %0h, actual %0h", want.bus_byte, got.bus_byte);
                    errors++;
                end
                if (got.buffer_index !== want.buffer_index) begin
                    $error("buffer_index: expected %0h, actual %0h",
                           want.buffer_index, got.buffer_index);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("** i2c_eeprom_paged_access_sequencer_core: FAILED **");
        $finish;
    end

    initial begin
        dir_row_t rows[$];
        dir_row_t row;
        int n;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        dev_addr = 8'd160;
        two_byte = 1'b0;
        page_log2 = 4'd3;
        poll_lim = 16'd1000;
        wr_delay = 16'd5;
        ph = SEQ_IDLE;
        dir_wr = 1'b0;
        cur_addr = '0;
        bytes_left = '0;
        chunk_left = '0;
        buf_pos = '0;
        poll_cnt = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // empty request, stray inputs, then reads across the top of the address space
        rows.push_back('{mk_in(MODE_REQ, 1, 16'hFFFF, 0, 16'hFFFF, 0, 0, 0), 1,
                         mk_out(CMD_DONE)});
        rows.push_back('{mk_in(MODE_SPARE, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1, 8'hFF),
                         0, '0});
        rows.push_back('{mk_in(MODE_DATA, 0, 0, 5, 0, 8'hFF, 0, 0), 0, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 5, 0, 0, 1, 8'hFF), 0, '0});
        rows.push_back('{mk_in(MODE_REQ, 0, 16'hFFFF, 2, 16'hFFFF, 0, 0, 0), -1, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 0, 0, 0, 0, 0), -1, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 0, 0, 0, 0, 0), -1, '0});
        rows.push_back('{mk_in(MODE_REQ, 1, 16'h1234, 16'h0009, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 0, 0, 0, 0, 0), -1, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 0, 0, 0, 0, 8'hFF), -1, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 0, 0, 0, 0, 0), -1, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 0, 0, 0, 0, 0), -1, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 0, 0, 0, 0, 0), -1, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 0, 0, 0, 0, 8'h00), -1, '0});
        // write with a busy request, a poll retry and a data nack
        rows.push_back('{mk_in(MODE_REQ, 1, 16'h0005, 3, 16'h0000, 0, 0, 0), -1, '0});
        rows.push_back('{mk_in(MODE_REQ, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 0, 0, 0, 1, 0), -1, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 0, 0, 0, 0, 0), -1, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 0, 0, 0, 0, 0), -1, '0});
        rows.push_back('{mk_in(MODE_DATA, 0, 0, 0, 0, 8'hFF, 0, 0), -1, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 0, 0, 0, 1, 0), -1, '0});
        rows.push_back('{mk_in(MODE_BUS, 0, 0, 0, 0, 0, 0, 0), -1, '0});

        foreach (rows[i]) begin
            row = rows[i];
            if (row.typed_n >= 0) begin
                predict(row.item);
                if (row.typed_n > 0) pending_res.push_back(row.typed_res);
                drive_typed(row.item);
            end else begin
                drive(row.item, n);
            end
        end

        run_random(30);
        drain();

        set_reg(CFG_DEVICE_ADDRESS, 16'd254);
        set_reg(CFG_TWO_BYTE_ADDR, 16'd1);
        set_reg(CFG_PAGE_LOG2, 16'd8);
        set_reg(CFG_POLL_LIMIT, 16'd1);
        set_reg(CFG_WRITE_DELAY, 16'd0);
        bulk_req = 1'b1;
        run_random(30);
        drain();

        set_reg(CFG_DEVICE_ADDRESS, 16'd0);
        set_reg(CFG_TWO_BYTE_ADDR, 16'd0);
        set_reg(CFG_PAGE_LOG2, 16'd3);
        set_reg(CFG_POLL_LIMIT, 16'd65535);
        set_reg(CFG_WRITE_DELAY, 16'd65535);
        run_random(30);
        drain();

        set_reg(CFG_DEVICE_ADDRESS, 16'd255);
        set_reg(CFG_TWO_BYTE_ADDR, 16'd1);
        set_reg(CFG_PAGE_LOG2, 16'd0);
        set_reg(CFG_POLL_LIMIT, 16'd0);
        set_reg(CFG_WRITE_DELAY, 16'h1234);
        run_random(30);
        drain();

        set_reg(CFG_DEVICE_ADDRESS, 16'h005A);
        set_reg(CFG_PAGE_LOG2, 16'd15);
        set_reg(CFG_POLL_LIMIT, 16'd3);
        set_reg(CFG_WRITE_DELAY, 16'd7);
        run_random(35);
        drain();

        set_reg(CFG_DEVICE_ADDRESS, 16'd160);
        set_reg(CFG_TWO_BYTE_ADDR, 16'd0);
        set_reg(CFG_PAGE_LOG2, 16'd5);
        set_reg(CFG_POLL_LIMIT, 16'd2);
        run_random(35);
        drain();

        if (errors == 0) begin
            $display("** i2c_eeprom_paged_access_sequencer_core: PASSED **");
        end else begin
            $display("** i2c_eeprom_paged_access_sequencer_core: FAILED **");
        end
        $finish;
    end

endmodule
